[hw/rtl/lld_pkg.sv]
// lld_pkg: shared types, constants and codes for the linked list deque engine
// no dependencies; used by every module of the block except lld_ram

package lld_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int LINK_W     = $clog2(DEPTH + 1);
    localparam int TALLY_W    = 7;
    localparam int TALLY_MAX  = (1 << TALLY_W) - 1;

    typedef logic [LINK_W-1:0]            t_link;
    typedef logic signed [DATA_WIDTH-1:0] t_data;

    // null link code
    localparam t_link NUL = LINK_W'(DEPTH);

    // operation codes
    localparam logic [3:0] OP_INS_FRONT  = 4'd0;
    localparam logic [3:0] OP_INS_BACK   = 4'd1;
    localparam logic [3:0] OP_DEL_FRONT  = 4'd2;
    localparam logic [3:0] OP_DEL_BACK   = 4'd3;
    localparam logic [3:0] OP_POP_FRONT  = 4'd4;
    localparam logic [3:0] OP_POP_BACK   = 4'd5;
    localparam logic [3:0] OP_PEEK_FRONT = 4'd6;
    localparam logic [3:0] OP_PEEK_BACK  = 4'd7;
    localparam logic [3:0] OP_INS_AFTER  = 4'd8;
    localparam logic [3:0] OP_INS_BEFORE = 4'd9;
    localparam logic [3:0] OP_REMOVE     = 4'd10;
    localparam logic [3:0] OP_CONTAINS   = 4'd11;
    localparam logic [3:0] OP_COUNT      = 4'd12;
    localparam logic [3:0] OP_LENGTH     = 4'd13;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [3:0]   operation;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] data_out;
        logic [TALLY_W-1:0] tally;
    } t_out_item;

    typedef enum logic [4:0] {
        C_NOP,
        C_LOAD,
        C_STATUS,
        C_LENGTH,
        C_END_RD,
        C_END_CAP,
        C_UNLINK_A,
        C_UNLINK_B,
        C_WALK_INIT,
        C_WALK_RD,
        C_WALK_CHK,
        C_TALLY_ONE,
        C_INS_SETUP,
        C_FREE_RD,
        C_FREE_UPD,
        C_LINK_A,
        C_LINK_B,
        C_EMIT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic [3:0] op;
        logic       full;
        logic       empty;
        logic       walk_end;
        logic       match;
        logic       out_busy;
    } t_stat;

endpackage

[hw/rtl/linked_list_deque_engine.sv]
// linked_list_deque_engine: top level, bounded deque of signed values in linked stores
// depends on lld_pkg, lld_ctrl, lld_datapath (which holds three lld_ram stores)
//
//  channel | valid        | ready        | item
//  --------+--------------+--------------+------------------------------
//  request | i_in_valid   | o_in_ready   | i_in_item  (operation,key,value)
//  result  | o_out_valid  | i_out_ready  | o_out_item (status,data_out,tally)
//
// one request at a time
// searches read the entry stores and then compare for each visited entry,
// followed by setup and link updates where the search inserts or removes
// reset builds the free chain at once through per-entry link valid bits
// a new request is taken while the previous result waits in the output register

module linked_list_deque_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lld_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lld_pkg::t_out_item o_out_item
);

    lld_pkg::t_cmd  cmd;
    lld_pkg::t_stat stat;

    lld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    lld_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_item),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

[hw/rtl/lld_ram.sv]
// lld_ram: generic single write port, single read port ram with registered read
// no dependencies

module lld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lld_datapath.sv]
// lld_datapath: entry stores, list pointers, walk cursor and result register
// depends on lld_pkg and lld_ram

module lld_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lld_pkg::t_cmd     i_cmd,
    input  lld_pkg::t_in_item i_item,
    input  logic              i_out_ready,
    output lld_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    output lld_pkg::t_out_item o_out_item
);

    localparam int IW = lld_pkg::IDX_W;
    localparam int LW = lld_pkg::LINK_W;

    logic [3:0]          r_op;
    lld_pkg::t_data      r_key;
    lld_pkg::t_data      r_value;
    lld_pkg::t_link      r_front;
    lld_pkg::t_link      r_back;
    lld_pkg::t_link      r_free;
    lld_pkg::t_link      r_count;
    lld_pkg::t_link      r_cursor;
    lld_pkg::t_link      r_steps;
    lld_pkg::t_link      r_at;
    lld_pkg::t_link      r_prev;
    lld_pkg::t_link      r_next;
    lld_pkg::t_link      r_new;
    lld_pkg::t_status    r_status;
    lld_pkg::t_data      r_data;
    logic [lld_pkg::TALLY_W-1:0] r_tally;
    logic                r_out_valid;
    lld_pkg::t_out_item  r_out;
    logic [lld_pkg::DEPTH-1:0] r_fl_vld;
    logic                r_fl_rvld;
    logic [IW-1:0]       r_fl_ridx;

    lld_pkg::t_link rd_link;
    logic [IW-1:0]  rd_addr;
    logic           val_we, fl_we, bl_we;
    logic [IW-1:0]  val_waddr, fl_waddr, bl_waddr;
    lld_pkg::t_data val_wdata;
    lld_pkg::t_link fl_wdata, bl_wdata;
    lld_pkg::t_data val_q;
    lld_pkg::t_link fl_raw, fl_q, bl_q;
    logic           match;

    // read address select
    always_comb begin
        case (i_cmd.op)
            lld_pkg::C_END_RD:  rd_link = r_op[0] ? r_back : r_front;
            lld_pkg::C_FREE_RD: rd_link = r_free;
            default:            rd_link = r_cursor;
        endcase
        rd_addr = rd_link[IW-1:0];
    end

    // write port select
    always_comb begin
        val_we    = 1'b0;
        val_waddr = r_free[IW-1:0];
        val_wdata = r_value;
        fl_we     = 1'b0;
        fl_waddr  = r_prev[IW-1:0];
        fl_wdata  = r_next;
        bl_we     = 1'b0;
        bl_waddr  = r_next[IW-1:0];
        bl_wdata  = r_prev;
        case (i_cmd.op)
            lld_pkg::C_FREE_UPD: begin
                val_we = 1'b1;
            end
            lld_pkg::C_UNLINK_A: begin
                fl_we = (r_prev != lld_pkg::NUL);
                bl_we = (r_next != lld_pkg::NUL);
            end
            lld_pkg::C_UNLINK_B: begin
                fl_we    = 1'b1;
                fl_waddr = r_at[IW-1:0];
                fl_wdata = r_free;
            end
            lld_pkg::C_LINK_A: begin
                fl_we    = 1'b1;
                fl_waddr = r_new[IW-1:0];
                bl_we    = 1'b1;
                bl_waddr = r_new[IW-1:0];
            end
            lld_pkg::C_LINK_B: begin
                fl_we    = (r_prev != lld_pkg::NUL);
                fl_wdata = r_new;
                bl_we    = (r_next != lld_pkg::NUL);
                bl_wdata = r_new;
            end
            default: begin
            end
        endcase
    end

    lld_ram #(.WIDTH(lld_pkg::DATA_WIDTH), .DEPTH(lld_pkg::DEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (rd_addr),
        .o_rdata (val_q)
    );

    lld_ram #(.WIDTH(LW), .DEPTH(lld_pkg::DEPTH)) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (fl_wdata),
        .i_raddr (rd_addr),
        .o_rdata (fl_raw)
    );

    lld_ram #(.WIDTH(LW), .DEPTH(lld_pkg::DEPTH)) u_bwd_ram (
        .i_clk   (i_clk),
        .i_we    (bl_we),
        .i_waddr (bl_waddr),
        .i_wdata (bl_wdata),
        .i_raddr (rd_addr),
        .o_rdata (bl_q)
    );

    // a forward link never written still holds its reset free chain
    assign fl_q  = r_fl_rvld ? fl_raw : (LW'(r_fl_ridx) + LW'(1));
    assign match = (val_q == r_key);

    always_ff @(posedge i_clk) begin
        r_fl_ridx <= rd_addr;
        if (!i_rst_n) begin
            r_fl_vld  <= '0;
            r_fl_rvld <= 1'b0;
        end else begin
            r_fl_rvld <= r_fl_vld[rd_addr];
            if (fl_we) begin
                r_fl_vld[fl_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= lld_pkg::NUL;
            r_back      <= lld_pkg::NUL;
            r_free      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == lld_pkg::C_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                lld_pkg::C_UNLINK_A: begin
                    if (r_prev == lld_pkg::NUL) begin
                        r_front <= r_next;
                    end
                    if (r_next == lld_pkg::NUL) begin
                        r_back <= r_prev;
                    end
                end
                lld_pkg::C_UNLINK_B: begin
                    r_free <= r_at;
                    if (r_count != '0) begin
                        r_count <= r_count - LW'(1);
                    end
                end
                lld_pkg::C_FREE_UPD: begin
                    r_free  <= fl_q;
                    r_count <= r_count + LW'(1);
                end
                lld_pkg::C_LINK_B: begin
                    if (r_prev == lld_pkg::NUL) begin
                        r_front <= r_new;
                    end
                    if (r_next == lld_pkg::NUL) begin
                        r_back <= r_new;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            lld_pkg::C_LOAD: begin
                r_op     <= i_item.operation;
                r_key    <= lld_pkg::t_data'(i_item.key);
                r_value  <= lld_pkg::t_data'(i_item.value);
                r_status <= lld_pkg::ST_OK;
                r_data   <= '0;
                r_tally  <= '0;
            end
            lld_pkg::C_STATUS: begin
                r_status <= i_cmd.status;
            end
            lld_pkg::C_LENGTH: begin
                r_tally <= (32'(r_count) > lld_pkg::TALLY_MAX)
                         ? lld_pkg::TALLY_W'(lld_pkg::TALLY_MAX)
                         : lld_pkg::TALLY_W'(r_count);
            end
            lld_pkg::C_END_RD: begin
                r_at <= rd_link;
            end
            lld_pkg::C_END_CAP: begin
                r_prev <= bl_q;
                r_next <= fl_q;
                if (r_op >= lld_pkg::OP_POP_FRONT) begin
                    r_data <= val_q;
                end
            end
            lld_pkg::C_WALK_INIT: begin
                r_cursor <= r_front;
                r_steps  <= '0;
            end
            lld_pkg::C_WALK_CHK: begin
                if (match && r_op == lld_pkg::OP_COUNT &&
                    32'(r_tally) != lld_pkg::TALLY_MAX) begin
                    r_tally <= r_tally + lld_pkg::TALLY_W'(1);
                end
                if (match && r_op != lld_pkg::OP_COUNT) begin
                    r_at   <= r_cursor;
                    r_prev <= bl_q;
                    r_next <= fl_q;
                end else begin
                    r_cursor <= fl_q;
                    r_steps  <= r_steps + LW'(1);
                end
            end
            lld_pkg::C_TALLY_ONE: begin
                r_tally <= lld_pkg::TALLY_W'(1);
            end
            lld_pkg::C_INS_SETUP: begin
                case (r_op)
                    lld_pkg::OP_INS_FRONT: begin
                        r_prev <= lld_pkg::NUL;
                        r_next <= r_front;
                    end
                    lld_pkg::OP_INS_BACK: begin
                        r_prev <= r_back;
                        r_next <= lld_pkg::NUL;
                    end
                    lld_pkg::OP_INS_AFTER: begin
                        r_prev <= r_at;
                    end
                    default: begin
                        r_next <= r_at;
                    end
                endcase
            end
            lld_pkg::C_FREE_UPD: begin
                r_new <= r_free;
            end
            lld_pkg::C_EMIT: begin
                r_out.status   <= r_status;
                r_out.data_out <= 32'(r_data);
                r_out.tally    <= r_tally;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.op       = r_op;
        o_stat.full     = (r_free == lld_pkg::NUL);
        o_stat.empty    = (r_front == lld_pkg::NUL);
        o_stat.walk_end = (r_cursor == lld_pkg::NUL) || (r_steps == lld_pkg::NUL);
        o_stat.match    = match;
        o_stat.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[hw/rtl/lld_ctrl.sv]
// lld_ctrl: request sequencer, issues one datapath command per cycle
// depends on lld_pkg

module lld_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  lld_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output lld_pkg::t_cmd  o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DISPATCH = 15'b000000000000010,
        S_END_RD   = 15'b000000000000100,
        S_END_CAP  = 15'b000000000001000,
        S_UNLINK_A = 15'b000000000010000,
        S_UNLINK_B = 15'b000000000100000,
        S_WALK_RD  = 15'b000000001000000,
        S_WALK_CHK = 15'b000000010000000,
        S_FOUND    = 15'b000000100000000,
        S_INS_SET  = 15'b000001000000000,
        S_FREE_RD  = 15'b000010000000000,
        S_FREE_UPD = 15'b000100000000000,
        S_LINK_A   = 15'b001000000000000,
        S_LINK_B   = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = lld_pkg::C_NOP;
        o_cmd.status = lld_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = lld_pkg::C_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op) inside
                    lld_pkg::OP_INS_FRONT, lld_pkg::OP_INS_BACK: begin
                        if (i_stat.full) begin
                            o_cmd.op     = lld_pkg::C_STATUS;
                            o_cmd.status = lld_pkg::ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_INS_SET;
                        end
                    end
                    lld_pkg::OP_DEL_FRONT, lld_pkg::OP_DEL_BACK,
                    lld_pkg::OP_POP_FRONT, lld_pkg::OP_POP_BACK,
                    lld_pkg::OP_PEEK_FRONT, lld_pkg::OP_PEEK_BACK: begin
                        if (i_stat.empty) begin
                            o_cmd.op     = lld_pkg::C_STATUS;
                            o_cmd.status = lld_pkg::ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_END_RD;
                        end
                    end
                    lld_pkg::OP_INS_AFTER, lld_pkg::OP_INS_BEFORE, lld_pkg::OP_REMOVE,
                    lld_pkg::OP_CONTAINS, lld_pkg::OP_COUNT: begin
                        o_cmd.op = lld_pkg::C_WALK_INIT;
                        n_state  = S_WALK_RD;
                    end
                    lld_pkg::OP_LENGTH: begin
                        o_cmd.op = lld_pkg::C_LENGTH;
                        n_state  = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_END_RD: begin
                o_cmd.op = lld_pkg::C_END_RD;
                n_state  = S_END_CAP;
            end
            S_END_CAP: begin
                o_cmd.op = lld_pkg::C_END_CAP;
                if (i_stat.op == lld_pkg::OP_PEEK_FRONT ||
                    i_stat.op == lld_pkg::OP_PEEK_BACK) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_UNLINK_A;
                end
            end
            S_UNLINK_A: begin
                o_cmd.op = lld_pkg::C_UNLINK_A;
                n_state  = S_UNLINK_B;
            end
            S_UNLINK_B: begin
                o_cmd.op = lld_pkg::C_UNLINK_B;
                n_state  = S_DONE;
            end
            S_WALK_RD: begin
                if (i_stat.walk_end) begin
                    // fell off the back: a count or contains ends here, any other search found no match
                    if (i_stat.op != lld_pkg::OP_CONTAINS &&
                        i_stat.op != lld_pkg::OP_COUNT) begin
                        o_cmd.op     = lld_pkg::C_STATUS;
                        o_cmd.status = lld_pkg::ST_NOTFOUND;
                    end
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = lld_pkg::C_WALK_RD;
                    n_state  = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                o_cmd.op = lld_pkg::C_WALK_CHK;
                if (i_stat.match && i_stat.op != lld_pkg::OP_COUNT) begin
                    n_state = S_FOUND;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_FOUND: begin
                if (i_stat.op == lld_pkg::OP_CONTAINS) begin
                    o_cmd.op = lld_pkg::C_TALLY_ONE;
                    n_state  = S_DONE;
                end else if (i_stat.op == lld_pkg::OP_REMOVE) begin
                    n_state = S_UNLINK_A;
                end else if (i_stat.full) begin
                    o_cmd.op     = lld_pkg::C_STATUS;
                    o_cmd.status = lld_pkg::ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_INS_SET;
                end
            end
            S_INS_SET: begin
                o_cmd.op = lld_pkg::C_INS_SETUP;
                n_state  = S_FREE_RD;
            end
            S_FREE_RD: begin
                o_cmd.op = lld_pkg::C_FREE_RD;
                n_state  = S_FREE_UPD;
            end
            S_FREE_UPD: begin
                o_cmd.op = lld_pkg::C_FREE_UPD;
                n_state  = S_LINK_A;
            end
            S_LINK_A: begin
                o_cmd.op = lld_pkg::C_LINK_A;
                n_state  = S_LINK_B;
            end
            S_LINK_B: begin
                o_cmd.op = lld_pkg::C_LINK_B;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = lld_pkg::C_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[tb/tb_linked_list_deque_engine.sv]
// tb_linked_list_deque_engine: self-checking bench for the linked list deque engine
// depends on lld_pkg and linked_list_deque_engine; a shadow deque predicts each result

module tb_linked_list_deque_engine;

    // shadow deque and result checker
    class deque_scoreboard;
        lld_pkg::t_data     shadow[$];
        lld_pkg::t_out_item pending[$];
        int                 errors;

        function void note_request(lld_pkg::t_in_item it);
            lld_pkg::t_out_item r;
            int                 pos;
            r = '0;
            r.status = lld_pkg::ST_OK;
            pos = -1;
            for (int j = 0; j < shadow.size(); j++) begin
                if (shadow[j] == it.key) begin
                    pos = j;
                    break;
                end
            end
            case (it.operation) inside
                lld_pkg::OP_INS_FRONT, lld_pkg::OP_INS_BACK: begin
                    if (shadow.size() >= lld_pkg::DEPTH) r.status = lld_pkg::ST_FULL;
                    else if (it.operation == lld_pkg::OP_INS_FRONT) shadow.push_front(it.value);
                    else shadow.push_back(it.value);
                end
                lld_pkg::OP_DEL_FRONT, lld_pkg::OP_DEL_BACK, lld_pkg::OP_POP_FRONT,
                lld_pkg::OP_POP_BACK, lld_pkg::OP_PEEK_FRONT, lld_pkg::OP_PEEK_BACK: begin
                    if (shadow.size() == 0) begin
                        r.status = lld_pkg::ST_EMPTY;
                    end else begin
                        if (it.operation >= lld_pkg::OP_POP_FRONT)
                            r.data_out = it.operation[0] ? shadow[$] : shadow[0];
                        if (it.operation <= lld_pkg::OP_POP_BACK) begin
                            if (it.operation[0]) void'(shadow.pop_back());
                            else void'(shadow.pop_front());
                        end
                    end
                end
                lld_pkg::OP_INS_AFTER, lld_pkg::OP_INS_BEFORE: begin
                    if (pos < 0) r.status = lld_pkg::ST_NOTFOUND;
                    else if (shadow.size() >= lld_pkg::DEPTH) r.status = lld_pkg::ST_FULL;
                    else if (it.operation == lld_pkg::OP_INS_AFTER)
                        shadow.insert(pos + 1, it.value);
                    else shadow.insert(pos, it.value);
                end
                lld_pkg::OP_REMOVE: begin
                    if (pos < 0) r.status = lld_pkg::ST_NOTFOUND;
                    else shadow.delete(pos);
                end
                lld_pkg::OP_CONTAINS: r.tally = lld_pkg::TALLY_W'(pos >= 0);
                lld_pkg::OP_COUNT: begin
                    foreach (shadow[j]) if (shadow[j] == it.key) r.tally++;
                end
                lld_pkg::OP_LENGTH: r.tally = lld_pkg::TALLY_W'(shadow.size());
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        task check_result(lld_pkg::t_out_item got);
            lld_pkg::t_out_item want;
            if (pending.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) report("status mismatch");
            if (got.data_out !== want.data_out) report("data_out mismatch");
            if (got.tally !== want.tally) report("tally mismatch");
        endtask

        task report(string what);
            $display("mismatch: %s at %0t", what, $time);
            errors++;
        endtask
    endclass

    logic               i_clk, i_rst_n;
    logic               i_in_valid, o_in_ready, o_out_valid, i_out_ready;
    lld_pkg::t_in_item  i_in_item;
    lld_pkg::t_out_item o_out_item;

    deque_scoreboard sb;
    bit  no_idle;
    int  hold_cycles;
    lld_pkg::t_data pool[8];

    linked_list_deque_engine dut (.*);

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    initial begin
        #50_000_000;
        $display("tb_linked_list_deque_engine: errors");
        $finish;
    end

    // receiver: random stalls, plus a long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out_item);
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(99) >= 17);
            end
        end
    end

    // valid stays high after an accepted item unless the sender idles
    task automatic send_request(input logic [3:0] op, input lld_pkg::t_data k,
                                input lld_pkg::t_data v);
        while (!no_idle && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_item <= '{operation: op, key: k, value: v};
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request('{operation: op, key: k, value: v});
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic lld_pkg::t_data pick_value();
        case ($urandom_range(9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return lld_pkg::t_data'($urandom);
            default: return pool[$urandom_range(7)];
        endcase
    endfunction

    initial begin
        logic [3:0] op;
        int         w;
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        hold_cycles = 0;
        no_idle = 1'b0;
        foreach (pool[j]) pool[j] = lld_pkg::t_data'($urandom);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty-list cases and extremes
        send_request(lld_pkg::OP_LENGTH, 0, 0);
        send_request(lld_pkg::OP_DEL_FRONT, 0, 0);
        send_request(lld_pkg::OP_POP_BACK, 0, 0);
        send_request(lld_pkg::OP_PEEK_FRONT, 0, 0);
        send_request(lld_pkg::OP_REMOVE, 5, 0);
        send_request(lld_pkg::OP_INS_AFTER, 5, 1);
        send_request(lld_pkg::OP_INS_FRONT, 0, 32'sh7FFFFFFF);
        send_request(lld_pkg::OP_INS_BACK, 0, 32'sh80000000);
        send_request(lld_pkg::OP_INS_AFTER, 32'sh7FFFFFFF, -1);
        send_request(lld_pkg::OP_INS_BEFORE, 32'sh80000000, 0);
        send_request(lld_pkg::OP_CONTAINS, -1, 0);
        send_request(lld_pkg::OP_COUNT, 0, 0);
        send_request(lld_pkg::OP_PEEK_BACK, 0, 0);
        send_request(lld_pkg::OP_POP_FRONT, 0, 0);
        send_request(lld_pkg::OP_DEL_BACK, 0, 0);
        send_request(lld_pkg::OP_REMOVE, -1, 0);
        send_request(4'd14, -1, -1);
        send_request(4'd15, 0, 0);

        // fill to full, refuse inserts, hold the receiver so the input stalls
        hold_cycles = 400;
        for (int j = 0; j < lld_pkg::DEPTH + 2; j++)
            send_request(lld_pkg::OP_INS_BACK, 0, pool[j % 8]);
        send_request(lld_pkg::OP_INS_AFTER, pool[0], 9);
        send_request(lld_pkg::OP_INS_BEFORE, 12345, 9);
        send_request(lld_pkg::OP_LENGTH, 0, 0);
        send_request(lld_pkg::OP_COUNT, pool[1], 0);
        drain();

        for (int n = 0; n < 1300; n++) begin
            if (n == 400) begin
                drain();
                no_idle = 1'b1;
            end
            if (n == 600) no_idle = 1'b0;
            // bias toward growth or shrink in phases
            w = $urandom_range(99);
            if ((n / 200) % 2 == 0) op = (w < 40) ? 4'($urandom_range(1)) :
                                          (w < 55) ? 4'($urandom_range(9, 8)) :
                                          4'($urandom_range(15));
            else op = (w < 40) ? 4'($urandom_range(5, 2)) : 4'($urandom_range(15));
            send_request(op, pick_value(), pick_value());
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_linked_list_deque_engine: clean");
        else
            $display("tb_linked_list_deque_engine: errors");
        $finish;
    end
endmodule
